// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared forms for the concurrent checks of the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/otf_pkg.sv =====
// ----------------------------------------------------------------------------
// otf_pkg
// constants, widths and shared types of the otsu threshold finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package otf_pkg;

   localparam int MAX_PIXELS = 1048576;
   localparam int LEVELS     = 256;
   localparam int HIST_SIZE  = 256;

   localparam int PIX_W   = 8;
   localparam int BIN_W   = $clog2(HIST_SIZE);
   localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W   = CNT_W + PIX_W;
   localparam int CROSS_W = SUM_W + CNT_W;
   localparam int NUM_W   = 2 * CROSS_W;
   localparam int DEN_W   = 2 * CNT_W;
   localparam int PROD_W  = NUM_W + DEN_W;

   localparam int DIG_W   = 8;
   localparam int DIGITS  = (CROSS_W + DIG_W - 1) / DIG_W;
   localparam int MB_W    = DIGITS * DIG_W;
   localparam int MCNT_W  = $clog2(DIGITS + 1);

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);

   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             counted;
      logic             last;
      logic             too_many;
   } otf_item_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] a;
      logic [MB_W-1:0]  b;
   } otf_mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } otf_mul_rsp_type;

   typedef struct packed {
      logic sweeping;
      logic result_pending;
   } otf_back_sts_type;

endpackage

// ===== hw/rtl/otf_channels.sv =====
// ----------------------------------------------------------------------------
// otf channels
// valid/ready channels for pixels in and thresholds out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface otf_req_if import otf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink   (input valid, input pixel, input last, output ready);
endinterface

interface otf_rsp_if import otf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] threshold;
   logic             too_many;

   modport source (output valid, output threshold, output too_many, input ready);
   modport sink   (input valid, input threshold, input too_many, output ready);
endinterface

// ===== hw/rtl/otf_front.sv =====
// ----------------------------------------------------------------------------
// otf_front
// takes pixel transactions, clamps the level and decides count or drop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otf_front import otf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   otf_req_if.sink      req_chan,
   input  logic         q_full,
   output logic         q_push,
   output otf_item_type q_item
);

   logic [CNT_W-1:0] total_ff, total_in;
   logic             drop_ff, drop_in;
   logic             counted;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign counted        = total_ff < CNT_W'(MAX_PIXELS);

   always_comb begin
      q_item.bin      = (int'(req_chan.pixel) >= LEVELS) ? BIN_W'(LEVELS - 1)
                                                         : BIN_W'(req_chan.pixel);
      q_item.counted  = counted;
      q_item.last     = req_chan.last;
      q_item.too_many = drop_ff || !counted;

      total_in = total_ff;
      drop_in  = drop_ff;
      if (q_push) begin
         if (req_chan.last) begin
            total_in = '0;
            drop_in  = 1'b0;
         end else begin
            total_in = total_ff + CNT_W'(counted);
            drop_in  = q_item.too_many;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         total_ff <= total_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// ===== hw/rtl/otf_queue.sv =====
// ----------------------------------------------------------------------------
// otf_queue
// short fifo of classified pixels between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otf_queue import otf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  otf_item_type push_item,
   output logic         full,
   input  logic         pop,
   output otf_item_type pop_item,
   output logic         valid
);

   otf_item_type      q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full     = count_ff == (QPTR_W + 1)'(QDEPTH);
   assign valid    = count_ff != '0;
   assign pop_item = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/otf_mul.sv =====
// ----------------------------------------------------------------------------
// otf_mul
// sequential multiplier, one 8-bit digit of b per cycle, msb digit first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otf_mul import otf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  otf_mul_req_type req,
   output otf_mul_rsp_type rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [MCNT_W-1:0]      cnt_ff, cnt_in;
   logic [NUM_W-1:0]       a_ff, a_in;
   logic [MB_W-1:0]        b_ff, b_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [NUM_W+DIG_W-1:0] part;

   assign part     = a_ff * b_ff[MB_W-1 -: DIG_W];
   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = MCNT_W'(DIGITS);
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff << DIG_W) + PROD_W'(part);
         b_in   = b_ff << DIG_W;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== hw/rtl/otf_back.sv =====
// ----------------------------------------------------------------------------
// otf_back
// histogram update, threshold sweep with exact variance compare, result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otf_back import otf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  otf_item_type     q_item,
   output logic             q_pop,
   output otf_mul_req_type  mul_req,
   input  otf_mul_rsp_type  mul_rsp,
   output otf_back_sts_type sts,
   otf_rsp_if.source        rsp_chan
);

   typedef enum logic [8:0] {
      ST_ACCUM = 9'b000000001,
      ST_RD    = 9'b000000010,
      ST_ACC   = 9'b000000100,
      ST_CHK   = 9'b000001000,
      ST_DIFF  = 9'b000010000,
      ST_SQ    = 9'b000100000,
      ST_LHS   = 9'b001000000,
      ST_RHS   = 9'b010000000,
      ST_FIN   = 9'b100000000
   } otf_state_type;

   otf_state_type          state_ff, state_in;

   logic [CNT_W-1:0]       hist_mem [HIST_SIZE];
   logic [CNT_W-1:0]       rd_ff;
   logic                   rdv_ff;
   logic [HIST_SIZE-1:0]   hv_ff, hv_in;

   logic                   s1_vld_ff, s1_vld_in;
   otf_item_type           s1_item_ff, s1_item_in;
   logic                   wr_vld_ff, wr_vld_in;
   logic [BIN_W-1:0]       wr_addr_ff, wr_addr_in;
   logic [CNT_W-1:0]       wr_val_ff, wr_val_in;

   logic [CNT_W-1:0]       n_ff, n_in;
   logic [SUM_W-1:0]       stot_ff, stot_in;
   logic                   drop_ff, drop_in;

   logic [BIN_W-1:0]       t_ff, t_in;
   logic [CNT_W-1:0]       w_ff, w_in;
   logic [SUM_W-1:0]       s_ff, s_in;
   logic [CROSS_W-1:0]     ta_ff, ta_in;
   logic [CROSS_W-1:0]     sn_ff, sn_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [PROD_W-1:0]      lhs_ff, lhs_in;
   logic [NUM_W-1:0]       best_num_ff, best_num_in;
   logic [DEN_W-1:0]       best_den_ff, best_den_in;
   logic [BIN_W-1:0]       best_t_ff, best_t_in;

   logic                   rsp_vld_ff, rsp_vld_in;
   logic [PIX_W-1:0]       thr_ff, thr_in;
   logic                   tm_ff, tm_in;

   logic                   rd_en;
   logic [BIN_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [CNT_W-1:0]       cnt_cur, cnt_new, hist_h, nw;
   logic [BIN_W+CNT_W-1:0] th;
   logic [CROSS_W-1:0]     ta_prod, sn_prod, diff;
   logic [DEN_W-1:0]       den_prod;
   logic                   last_t;

   assign q_pop   = q_valid && (state_ff == ST_ACCUM) && !(s1_vld_ff && s1_item_ff.last);
   assign rd_en   = q_pop || (state_ff == ST_RD);
   assign rd_addr = (state_ff == ST_RD) ? t_ff : q_item.bin;
   assign wr_en   = s1_vld_ff && s1_item_ff.counted;

   // back-to-back hits on one bin take the value written last cycle
   assign cnt_cur  = (wr_vld_ff && (wr_addr_ff == s1_item_ff.bin)) ? wr_val_ff
                   : (rdv_ff ? rd_ff : '0);
   assign cnt_new  = cnt_cur + 1'b1;
   assign hist_h   = rdv_ff ? rd_ff : '0;
   assign th       = t_ff * hist_h;
   assign nw       = n_ff - w_ff;
   assign ta_prod  = stot_ff * w_ff;
   assign sn_prod  = s_ff * n_ff;
   assign den_prod = w_ff * nw;
   assign diff     = (ta_ff >= sn_ff) ? ta_ff - sn_ff : sn_ff - ta_ff;
   assign last_t   = t_ff == BIN_W'(LEVELS - 1);

   assign sts.sweeping       = state_ff != ST_ACCUM;
   assign sts.result_pending = rsp_vld_ff;

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.threshold = thr_ff;
   assign rsp_chan.too_many  = tm_ff;

   always_comb begin
      state_in    = state_ff;
      hv_in       = hv_ff;
      s1_vld_in   = q_pop;
      s1_item_in  = q_pop ? q_item : s1_item_ff;
      wr_vld_in   = wr_vld_ff;
      wr_addr_in  = wr_addr_ff;
      wr_val_in   = wr_val_ff;
      n_in        = n_ff;
      stot_in     = stot_ff;
      drop_in     = drop_ff;
      t_in        = t_ff;
      w_in        = w_ff;
      s_in        = s_ff;
      ta_in       = ta_ff;
      sn_in       = sn_ff;
      den_in      = den_ff;
      num_in      = num_ff;
      lhs_in      = lhs_ff;
      best_num_in = best_num_ff;
      best_den_in = best_den_ff;
      best_t_in   = best_t_ff;
      rsp_vld_in  = rsp_chan.ready ? 1'b0 : rsp_vld_ff;
      thr_in      = thr_ff;
      tm_in       = tm_ff;
      mul_req     = '0;

      if (wr_en) begin
         hv_in[s1_item_ff.bin] = 1'b1;
         wr_vld_in  = 1'b1;
         wr_addr_in = s1_item_ff.bin;
         wr_val_in  = cnt_new;
         n_in       = n_ff + 1'b1;
         stot_in    = stot_ff + SUM_W'(s1_item_ff.bin);
      end
      if (s1_vld_ff && s1_item_ff.last) begin
         drop_in = s1_item_ff.too_many;
      end

      case (state_ff)
         ST_ACCUM: begin
            if (s1_vld_ff && s1_item_ff.last) begin
               state_in    = ST_RD;
               t_in        = '0;
               w_in        = '0;
               s_in        = '0;
               best_num_in = '0;
               best_den_in = DEN_W'(1);
               best_t_in   = '0;
            end
         end
         ST_RD: begin
            // each bin is cleared as the sweep reads it
            hv_in[t_ff] = 1'b0;
            wr_vld_in   = 1'b0;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            w_in     = w_ff + hist_h;
            s_in     = s_ff + SUM_W'(th);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (w_ff == '0) begin
               if (last_t) begin
                  state_in = ST_FIN;
               end else begin
                  t_in     = t_ff + 1'b1;
                  state_in = ST_RD;
               end
            end else if (w_ff >= n_ff) begin
               state_in = ST_FIN;
            end else begin
               ta_in    = ta_prod;
               sn_in    = sn_prod;
               den_in   = den_prod;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            mul_req.start = 1'b1;
            mul_req.a     = NUM_W'(diff);
            mul_req.b     = MB_W'(diff);
            state_in      = ST_SQ;
         end
         ST_SQ: begin
            if (mul_rsp.done) begin
               num_in        = mul_rsp.prod[NUM_W-1:0];
               mul_req.start = 1'b1;
               mul_req.a     = mul_rsp.prod[NUM_W-1:0];
               mul_req.b     = MB_W'(best_den_ff);
               state_in      = ST_LHS;
            end
         end
         ST_LHS: begin
            if (mul_rsp.done) begin
               lhs_in        = mul_rsp.prod;
               mul_req.start = 1'b1;
               mul_req.a     = best_num_ff;
               mul_req.b     = MB_W'(den_ff);
               state_in      = ST_RHS;
            end
         end
         ST_RHS: begin
            if (mul_rsp.done) begin
               if (lhs_ff > mul_rsp.prod) begin
                  best_num_in = num_ff;
                  best_den_in = den_ff;
                  best_t_in   = t_ff;
               end
               if (last_t) begin
                  state_in = ST_FIN;
               end else begin
                  t_in     = t_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               thr_in     = PIX_W'(best_t_ff);
               tm_in      = drop_ff;
               n_in       = '0;
               stot_in    = '0;
               state_in   = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff  <= hist_mem[rd_addr];
         rdv_ff <= hv_ff[rd_addr];
      end
      if (wr_en) begin
         hist_mem[s1_item_ff.bin] <= cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      wr_addr_ff  <= wr_addr_in;
      wr_val_ff   <= wr_val_in;
      t_ff        <= t_in;
      w_ff        <= w_in;
      s_ff        <= s_in;
      ta_ff       <= ta_in;
      sn_ff       <= sn_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      lhs_ff      <= lhs_in;
      best_num_ff <= best_num_in;
      best_den_ff <= best_den_in;
      best_t_ff   <= best_t_in;
      thr_ff      <= thr_in;
      tm_ff       <= tm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ACCUM;
         hv_ff      <= '0;
         s1_vld_ff  <= 1'b0;
         wr_vld_ff  <= 1'b0;
         n_ff       <= '0;
         stot_ff    <= '0;
         drop_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         hv_ff      <= hv_in;
         s1_vld_ff  <= s1_vld_in;
         wr_vld_ff  <= wr_vld_in;
         n_ff       <= n_in;
         stot_ff    <= stot_in;
         drop_ff    <= drop_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

// ===== hw/rtl/otsu_threshold_finder.sv =====
// ----------------------------------------------------------------------------
// otsu_threshold_finder
// 256-bin histogram of 8-bit pixels and exact otsu threshold per image
//
//   channel    dir  handshake    payload
//   req_chan   in   valid/ready  pixel[7:0], last
//   rsp_chan   out  valid/ready  threshold[7:0], too_many
//
// pixels are taken one per cycle while counting; a 4-entry queue absorbs
// short stalls. the pixel marked last starts a threshold sweep, which makes
// three passes of the shared 8-bit digit multiplier for each level that
// splits the image; the input stalls once the queue fills.
// synchronous reset clears the histogram through valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module otsu_threshold_finder import otf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   otf_req_if.sink    req_chan,
   otf_rsp_if.source  rsp_chan
);

   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_valid;
   otf_item_type     push_item;
   otf_item_type     pop_item;
   otf_mul_req_type  mul_req;
   otf_mul_rsp_type  mul_rsp;
   otf_back_sts_type back_sts;

   otf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   otf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .valid     (q_valid)
   );

   otf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   otf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (pop_item),
      .q_pop    (q_pop),
      .mul_req  (mul_req),
      .mul_rsp  (mul_rsp),
      .sts      (back_sts),
      .rsp_chan (rsp_chan)
   );

   `ASSERT_IMPLIES(a_no_pop_in_sweep, clock, reset, back_sts.sweeping, !q_pop)
   `ASSERT_IMPLIES(a_pop_needs_item, clock, reset, q_pop, q_valid)
   `ASSERT_IMPLIES(a_sweep_ends_in_result, clock, reset, $fell(back_sts.sweeping), back_sts.result_pending)
   `ASSERT_ALWAYS(a_queue_no_overflow, clock, reset, !(q_push && q_full))

endmodule

// ===== tb/otsu_threshold_finder_checker.sv =====
// ----------------------------------------------------------------------------
// otsu_threshold_finder_checker
// watches the pixel and threshold channels, keeps its own histogram of each
// image, works out the exact otsu threshold when the last pixel is taken and
// compares every threshold transaction against the oldest one still due
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otsu_threshold_finder_checker import otf_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   otf_req_if    req_chan,
   otf_rsp_if    rsp_chan,
   output int    mismatches,
   output int    outstanding
);

   typedef struct packed {
      logic [PIX_W-1:0] threshold;
      logic             too_many;
   } threshold_result_type;

   logic [31:0]          bin_count [HIST_SIZE];
   logic [31:0]          pixel_count;
   logic                 dropped;
   threshold_result_type thresholds_due [$];
   threshold_result_type oldest_due;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic clear_image();
      foreach (bin_count[lvl]) bin_count[lvl] = '0;
      pixel_count = '0;
      dropped     = 1'b0;
   endtask

   // exact between-class variance, compared by cross-multiplication
   function automatic logic [PIX_W-1:0] best_threshold();
      logic [63:0]      grand_sum, cum_count, cum_sum, lo_side, hi_side, gap;
      logic [191:0]     var_num, var_den, best_num, best_den;
      logic [PIX_W-1:0] best_level;
      logic             stop;
      grand_sum  = '0;
      cum_count  = '0;
      cum_sum    = '0;
      best_num   = '0;
      best_den   = 192'd1;
      best_level = '0;
      stop       = 1'b0;
      for (int lvl = 0; lvl < LEVELS; lvl++) grand_sum += 64'(lvl) * bin_count[lvl];
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         cum_count += bin_count[lvl];
         cum_sum   += 64'(lvl) * bin_count[lvl];
         if (!stop && cum_count != 0) begin
            if (cum_count >= pixel_count) begin
               stop = 1'b1;
            end else begin
               lo_side = grand_sum * cum_count;
               hi_side = cum_sum * pixel_count;
               gap     = (lo_side >= hi_side) ? lo_side - hi_side : hi_side - lo_side;
               var_num = 192'(gap) * 192'(gap);
               var_den = 192'(cum_count * (pixel_count - cum_count));
               if (var_num * best_den > best_num * var_den) begin
                  best_num   = var_num;
                  best_den   = var_den;
                  best_level = PIX_W'(lvl);
               end
            end
         end
      end
      return best_level;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_image();
         thresholds_due.delete();
         mismatches = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (pixel_count < MAX_PIXELS) begin
               bin_count[req_chan.pixel]++;
               pixel_count++;
            end else begin
               dropped = 1'b1;
            end
            if (req_chan.last) begin
               thresholds_due.push_back('{best_threshold(), dropped});
               clear_image();
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (thresholds_due.size() == 0) begin
               report_mismatch("threshold transaction with none due",
                               int'(rsp_chan.threshold), -1);
            end else begin
               oldest_due = thresholds_due.pop_front();
               if (rsp_chan.threshold !== oldest_due.threshold)
                  report_mismatch("threshold", int'(rsp_chan.threshold),
                                  int'(oldest_due.threshold));
               if (rsp_chan.too_many !== oldest_due.too_many)
                  report_mismatch("too_many", int'(rsp_chan.too_many),
                                  int'(oldest_due.too_many));
            end
         end
      end
      outstanding = thresholds_due.size();
   end

endmodule

// ===== tb/otsu_threshold_finder_test.sv =====
// ----------------------------------------------------------------------------
// otsu_threshold_finder_test
// drives images of grey pixels into the threshold finder: a few hand-picked
// images, then random images of several shapes and sizes, with random gaps
// on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otsu_threshold_finder_test import otf_pkg::*;;

   localparam int unsigned CYCLE_LIMIT   = 40_000_000;
   localparam int unsigned RANDOM_PIXELS = 1030;
   localparam int unsigned SETTLE_CYCLES = 300;

   typedef enum int unsigned {
      SHAPE_UNIFORM,
      SHAPE_TWO_PEAKS,
      SHAPE_DARK,
      SHAPE_FLAT,
      SHAPE_EXTREMES
   } image_shape_type;

   logic        clock;
   logic        reset;
   logic        sender_steady;
   logic        receiver_steady;
   int          mismatches;
   int          outstanding;
   int unsigned cycle_count = 0;
   int unsigned images_sent = 0;
   int unsigned pixels_sent = 0;

   otf_req_if req_chan ();
   otf_rsp_if rsp_chan ();

   otsu_threshold_finder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   otsu_threshold_finder_checker threshold_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("otsu_threshold_finder_test NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= receiver_steady || ($urandom_range(99) >= 17);
   end

   task automatic send_pixel(input logic [PIX_W-1:0] level, input logic is_last);
      while (!sender_steady && $urandom_range(99) < 17) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= level;
      req_chan.last  <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      pixels_sent++;
      if (is_last) images_sent++;
   endtask

   task automatic send_image(input int unsigned size, input image_shape_type shape);
      logic [PIX_W-1:0] peak_a, peak_b, level;
      int unsigned      spread;
      peak_a = PIX_W'($urandom_range(255));
      peak_b = PIX_W'($urandom_range(255));
      spread = $urandom_range(31);
      for (int unsigned idx = 0; idx < size; idx++) begin
         case (shape)
            SHAPE_UNIFORM:   level = PIX_W'($urandom_range(255));
            SHAPE_TWO_PEAKS: level = ($urandom_range(1) ? peak_a : peak_b)
                                     + PIX_W'($urandom_range(spread));
            SHAPE_DARK:      level = PIX_W'($urandom_range(spread));
            SHAPE_FLAT:      level = peak_a;
            default:         level = $urandom_range(1) ? 8'hff : 8'h00;
         endcase
         send_pixel(level, idx == size - 1);
      end
   endtask

   // sender holds off until every threshold due has come back
   task automatic wait_for_thresholds();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.pixel  = '0;
      req_chan.last   = 1'b0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      reset           = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single pixel images and a two-pixel image, both extremes
      send_pixel(8'h00, 1'b1);
      send_pixel(8'hff, 1'b1);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hff, 1'b1);
      // one level only, no split, then images of several levels
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h80, 1'b1);
      send_pixel(8'hff, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hff, 1'b0);
      send_pixel(8'h00, 1'b1);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd50, 1'b0);
      send_pixel(8'd90, 1'b1);
      for (int bit_pos = 0; bit_pos < PIX_W; bit_pos++)
         send_pixel(PIX_W'(1) << bit_pos, bit_pos == PIX_W - 1);
      wait_for_thresholds();

      pixels_sent = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         sender_steady   = pixels_sent >= 400 && pixels_sent < 600;
         receiver_steady = pixels_sent >= 450 && pixels_sent < 650;
         send_image(($urandom_range(9) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1),
                    image_shape_type'($urandom_range(SHAPE_EXTREMES)));
         if ($urandom_range(9) == 0) wait_for_thresholds();
      end
      wait_for_thresholds();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d images: hand-picked ones and random images of five shapes,",
               images_sent);
      $display("%0d random pixels in all, with and without gaps on both sides", pixels_sent);
      if (mismatches == 0) begin
         $display("otsu_threshold_finder_test OK");
      end else begin
         $display("otsu_threshold_finder_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== otsu_threshold_finder.f =====
+incdir+hw/rtl
hw/rtl/otf_pkg.sv
hw/rtl/otf_channels.sv
hw/rtl/otf_front.sv
hw/rtl/otf_queue.sv
hw/rtl/otf_mul.sv
hw/rtl/otf_back.sv
hw/rtl/otsu_threshold_finder.sv
tb/otsu_threshold_finder_checker.sv
tb/otsu_threshold_finder_test.sv
